[design/drlp_pkg.sv]
// Package for the decimal record line parser.
// Types, codes and constants shared by the parser core and the top level.
// No dependencies.
package drlp_pkg;

  // Width of a parsed value and derived limits
  localparam int unsigned ValueBits = 32;
  localparam int unsigned MagBits   = ValueBits;      // holds 2^(ValueBits-1)
  localparam int unsigned ProdBits  = ValueBits + 4;  // 10*mag + 9 fits
  localparam logic [MagBits-1:0]   MagLimit = MagBits'(1) << (ValueBits - 1);
  localparam logic [ValueBits-1:0] PosMax   = ValueBits'(MagLimit - MagBits'(1));

  // Character codes
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSemi  = 8'h3B;

  // Position of the next token within a line
  typedef enum logic [1:0] {
    PhComment = 2'd0,
    PhFirst   = 2'd1,
    PhSecond  = 2'd2,
    PhThird   = 2'd3
  } line_phase_e;

  // Progress through one number token
  typedef enum logic [1:0] {
    NpLead   = 2'd0,
    NpSign   = 2'd1,
    NpDigits = 2'd2
  } number_phase_e;

  // Event codes on the result channel
  typedef enum logic [1:0] {
    EvNone   = 2'd0,
    EvRecord = 2'd1,
    EvBad    = 2'd2,
    EvShort  = 2'd3
  } event_e;

  // One result from the parser core
  typedef struct packed {
    logic                 emit;
    event_e               ev;
    logic [ValueBits-1:0] first;
    logic [ValueBits-1:0] second;
    logic [ValueBits-1:0] third;
    logic                 done;
    logic                 failed;
  } parse_res_t;

endpackage

[design/drlp_parse_core.sv]
// Parser core: line and token state, number accumulation, event decode.
// Consumes one byte per strobe; result is combinational from current state and input byte.
// Depends on drlp_pkg.
module drlp_parse_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   byte_valid_i,
  input  logic [7:0]             byte_i,
  input  logic                   last_i,
  output drlp_pkg::parse_res_t   res_o
);

  drlp_pkg::line_phase_e   phase_q, phase_d;
  drlp_pkg::number_phase_e np_q, np_d;
  logic token_open_q, token_open_d;
  logic invalid_q, invalid_d;
  logic minus_q, minus_d;
  logic digit_q, digit_d;
  logic err_q, err_d;
  logic [drlp_pkg::MagBits-1:0]   mag_q, mag_d;
  logic [drlp_pkg::ValueBits-1:0] first_q, first_d;
  logic [drlp_pkg::ValueBits-1:0] second_q, second_d;
  logic [drlp_pkg::ValueBits-1:0] third_q, third_d;

  logic is_sep, is_nl, is_digit, is_lead_ws, is_sign, good;
  logic [drlp_pkg::ProdBits-1:0]  prod;
  logic [drlp_pkg::ValueBits-1:0] value;
  drlp_pkg::event_e        ev;
  drlp_pkg::line_phase_e   phase_tok;

  // Character classes
  assign is_sep     = (byte_i == drlp_pkg::ChTab) || (byte_i == drlp_pkg::ChSpace) ||
                      (byte_i == drlp_pkg::ChSemi);
  assign is_nl      = (byte_i == drlp_pkg::ChNl);
  assign is_digit   = (byte_i >= drlp_pkg::ChZero) && (byte_i <= drlp_pkg::ChNine);
  assign is_lead_ws = (byte_i == drlp_pkg::ChVt) || (byte_i == drlp_pkg::ChFf) ||
                      (byte_i == drlp_pkg::ChCr);
  assign is_sign    = (byte_i == drlp_pkg::ChPlus) || (byte_i == drlp_pkg::ChMinus);
  assign good       = digit_q && !invalid_q;

  // mag*10 + digit (mag*8 + mag*2); saturation when it passes the limit
  assign prod = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} +
                drlp_pkg::ProdBits'(byte_i[3:0]);

  // Signed value of the finished token
  always_comb begin
    if (minus_q) begin
      value = drlp_pkg::ValueBits'(~mag_q + drlp_pkg::MagBits'(1));
    end else if (mag_q > drlp_pkg::MagBits'(drlp_pkg::PosMax)) begin
      value = drlp_pkg::PosMax;
    end else begin
      value = drlp_pkg::ValueBits'(mag_q);
    end
  end

  // Next state and result
  always_comb begin
    phase_d      = phase_q;
    np_d         = np_q;
    token_open_d = token_open_q;
    invalid_d    = invalid_q;
    minus_d      = minus_q;
    digit_d      = digit_q;
    mag_d        = mag_q;
    first_d      = first_q;
    second_d     = second_q;
    third_d      = third_q;
    err_d        = err_q;
    ev           = drlp_pkg::EvNone;
    phase_tok    = phase_q;

    if (is_sep || is_nl) begin
      // token end
      if (token_open_q) begin
        case (phase_q)
          drlp_pkg::PhComment: begin
            phase_tok = drlp_pkg::PhFirst;
          end
          drlp_pkg::PhFirst: begin
            first_d   = value;
            phase_tok = good ? drlp_pkg::PhSecond : drlp_pkg::PhComment;
            ev        = good ? drlp_pkg::EvNone : drlp_pkg::EvBad;
          end
          drlp_pkg::PhSecond: begin
            second_d  = value;
            phase_tok = good ? drlp_pkg::PhThird : drlp_pkg::PhComment;
            ev        = good ? drlp_pkg::EvNone : drlp_pkg::EvBad;
          end
          default: begin
            third_d = value;
            if (good) begin
              ev = drlp_pkg::EvRecord;
            end else begin
              phase_tok = drlp_pkg::PhComment;
              ev        = drlp_pkg::EvBad;
            end
          end
        endcase
        token_open_d = 1'b0;
        np_d         = drlp_pkg::NpLead;
        invalid_d    = 1'b0;
        minus_d      = 1'b0;
        digit_d      = 1'b0;
        mag_d        = '0;
      end
      phase_d = phase_tok;
      // line end: short line check
      if (is_nl) begin
        phase_d = drlp_pkg::PhComment;
        if ((ev == drlp_pkg::EvNone) &&
            ((phase_tok == drlp_pkg::PhFirst) || (phase_tok == drlp_pkg::PhSecond))) begin
          ev = drlp_pkg::EvShort;
        end
      end
    end else begin
      // character within a token
      token_open_d = 1'b1;
      if (is_digit) begin
        if (prod > drlp_pkg::ProdBits'(drlp_pkg::MagLimit)) begin
          mag_d = drlp_pkg::MagLimit;
        end else begin
          mag_d = prod[drlp_pkg::MagBits-1:0];
        end
        digit_d = 1'b1;
        np_d    = drlp_pkg::NpDigits;
      end else if ((np_q == drlp_pkg::NpLead) && is_lead_ws) begin
        np_d = np_q;
      end else if ((np_q == drlp_pkg::NpLead) && is_sign) begin
        minus_d = (byte_i == drlp_pkg::ChMinus);
        np_d    = drlp_pkg::NpSign;
      end else begin
        invalid_d = 1'b1;
      end
    end

    // chunk error tracking
    if ((ev == drlp_pkg::EvBad) || (ev == drlp_pkg::EvShort)) begin
      err_d = 1'b1;
    end
    res_o.failed = last_i && err_d;
    if (last_i) begin
      err_d = 1'b0;
    end

    res_o.emit   = (ev != drlp_pkg::EvNone) || last_i;
    res_o.ev     = ev;
    res_o.done   = last_i;
    res_o.first  = (ev == drlp_pkg::EvRecord) ? first_d  : '0;
    res_o.second = (ev == drlp_pkg::EvRecord) ? second_d : '0;
    res_o.third  = (ev == drlp_pkg::EvRecord) ? third_d  : '0;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= drlp_pkg::PhComment;
      np_q         <= drlp_pkg::NpLead;
      token_open_q <= 1'b0;
      invalid_q    <= 1'b0;
      minus_q      <= 1'b0;
      digit_q      <= 1'b0;
      err_q        <= 1'b0;
      mag_q        <= '0;
      first_q      <= '0;
      second_q     <= '0;
      third_q      <= '0;
    end else if (byte_valid_i) begin
      phase_q      <= phase_d;
      np_q         <= np_d;
      token_open_q <= token_open_d;
      invalid_q    <= invalid_d;
      minus_q      <= minus_d;
      digit_q      <= digit_d;
      err_q        <= err_d;
      mag_q        <= mag_d;
      first_q      <= first_d;
      second_q     <= second_d;
      third_q      <= third_d;
    end
  end

endmodule

[design/decimal_record_line_parser_unit.sv]
// Top level of the decimal record line parser.
// Input register, parser core and output register. Depends on drlp_pkg and
// drlp_parse_core.
//
// Usage:
//  - Slave side takes one character per beat: s_axis_tdata[7:0] is the byte,
//    s_axis_tlast marks the last byte of a chunk.
//  - Master side gives a beat for every record, bad number, short line, and
//    for every byte carrying tlast. tdata holds first, second and third value
//    (32 bits each, lowest first); tuser[1:0] is the event code
//    (0 none, 1 record, 2 bad number, 3 short line), tuser[2] is the chunk
//    failure flag; tlast closes a chunk.
//  - A byte held in the input register passes the parser core; its result is
//    registered in the output register, which drives the master side.
//  - Throughput: one byte per cycle while the output side does not stall; the
//    parser state update is a single pass of logic between the two registers.
//  - Stall: while the output register holds an untaken beat, the pipeline
//    holds; the input register still takes one further byte if it is empty.
//  - Reset clears both valid flags and the parser state: the next line starts
//    at its comment token and no chunk error is pending.
module decimal_record_line_parser_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] byte_in
  input  logic         s_axis_tlast,   // chunk_last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,   // [31:0] first, [63:32] second, [95:64] third
  output logic [2:0]   m_axis_tuser,   // [1:0] event_res, [2] chunk_failed
  output logic         m_axis_tlast    // chunk_done
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       advance;
  logic       out_valid_q;
  logic [95:0] out_data_q;
  logic [2:0]  out_user_q;
  logic        out_last_q;
  drlp_pkg::parse_res_t res;

  // Pipeline moves when the output register is free or being drained
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  drlp_parse_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_valid_q && advance),
    .byte_i       (in_byte_q),
    .last_i       (in_last_q),
    .res_o        (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && res.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && res.emit) begin
      out_data_q <= {res.third, res.second, res.first};
      out_user_q <= {res.failed, res.ev};
      out_last_q <= res.done;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule
